>>> src/wft_pkg.sv
// Constants and types shared by the word frequency table.
package wft_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int MAX_WORD_LEN = 49;
    localparam int TOP_RANKS    = 10;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int POS_W   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CHAR_AW = $clog2(TABLE_DEPTH * MAX_WORD_LEN);
    localparam int RANK_W  = 4;
    localparam int CNT_W   = 32;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_LOOKUP = 11'b00000000010,
        ST_META   = 11'b00000000100,
        ST_CRD    = 11'b00000001000,
        ST_CCMP   = 11'b00000010000,
        ST_APPEND = 11'b00000100000,
        ST_QRD    = 11'b00001000000,
        ST_QCHK   = 11'b00010000000,
        ST_ORD    = 11'b00100000000,
        ST_OWAIT  = 11'b01000000000,
        ST_OHOLD  = 11'b10000000000
    } state_t;

endpackage

>>> src/word_frequency_table.sv
// Word frequency table: distinct word counting with ranked lookup.
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  input   | s_valid s_ready s_op s_ch s_word_end s_rank       | in
//  result  | m_valid m_ready m_valid_res m_out_char m_count    | out
//          | m_last m_distinct m_overflowed                   |
//
// A character beat that does not end a word is stored in the word buffer. A word end walks the
// table in order, comparing the length and then each character, and a new word is then
// stored one character at a time. A rank query makes rank+1 passes over the table, then
// sends one result beat per character, each held until the sink takes it. Reset clears only
// the state, the fill count, the word length, the overflow flag and the output valid.
module word_frequency_table
    import wft_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [7:0]        s_ch,
    input  logic              s_word_end,
    input  logic [RANK_W-1:0] s_rank,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_valid_res,
    output logic [7:0]        m_out_char,
    output logic [CNT_W-1:0]  m_count,
    output logic              m_last,
    output logic [10:0]       m_distinct,
    output logic              m_overflowed
);

    state_t state_reg, state_next;

    logic [7:0]             char_mem [TABLE_DEPTH*MAX_WORD_LEN];
    logic [LEN_W+CNT_W-1:0] meta_mem [TABLE_DEPTH];
    logic [7:0]             buf_reg  [MAX_WORD_LEN];

    logic [7:0]             char_rdata_reg;
    logic [LEN_W+CNT_W-1:0] meta_rdata_reg;
    logic [7:0]             buf_rdata_reg;
    logic [CHAR_AW-1:0]     char_raddr, char_waddr;
    logic [IDX_W-1:0]       meta_raddr;
    logic [POS_W-1:0]       buf_raddr;
    logic                   char_we, meta_we;
    logic [IDX_W-1:0]       meta_waddr;
    logic [LEN_W+CNT_W-1:0] meta_wdata;

    logic [USED_W-1:0] used_reg, e_reg;
    logic [LEN_W-1:0]  wlen_reg, new_len;
    logic [POS_W-1:0]  k_reg;
    logic              full_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RANK_W-1:0] rank_reg, pass_reg;
    logic              have_prev_reg, have_best_reg;
    logic [CNT_W-1:0]  prev_cnt_reg, best_cnt_reg;
    logic [IDX_W-1:0]  prev_idx_reg, best_idx_reg;
    logic [LEN_W-1:0]  best_len_reg;
    logic              m_valid_reg;

    logic [LEN_W-1:0]  rd_len;
    logic [CNT_W-1:0]  rd_cnt;
    logic              cand, take, close_w, last_pos;

    assign rd_len   = meta_rdata_reg[LEN_W+CNT_W-1:CNT_W];
    assign rd_cnt   = meta_rdata_reg[CNT_W-1:0];
    assign new_len  = wlen_reg + LEN_W'(1);
    assign close_w  = s_word_end || (new_len == LEN_W'(MAX_WORD_LEN));
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_distinct   = 11'(used_reg);
    assign m_overflowed = full_reg;

    assign cand = !have_prev_reg || (rd_cnt < prev_cnt_reg) ||
                  ((rd_cnt == prev_cnt_reg) && (e_reg[IDX_W-1:0] > prev_idx_reg));
    assign take = cand && (!have_best_reg || (rd_cnt > best_cnt_reg));

    always_comb begin
        char_raddr = CHAR_AW'(e_reg[IDX_W-1:0]) * CHAR_AW'(MAX_WORD_LEN) + CHAR_AW'(k_reg);
        if (state_reg == ST_ORD) begin
            char_raddr = CHAR_AW'(best_idx_reg) * CHAR_AW'(MAX_WORD_LEN) + CHAR_AW'(k_reg);
        end
        char_waddr = CHAR_AW'(used_reg[IDX_W-1:0]) * CHAR_AW'(MAX_WORD_LEN)
                     + CHAR_AW'(k_reg);
        char_we    = (state_reg == ST_APPEND);
        meta_raddr = e_reg[IDX_W-1:0];
        last_pos   = (LEN_W'(k_reg) + LEN_W'(1) == wlen_reg);
        buf_raddr  = k_reg;
        if (state_reg == ST_LOOKUP) begin
            buf_raddr = '0;
        end
        if (state_reg == ST_APPEND && !last_pos) begin
            buf_raddr = k_reg + POS_W'(1);
        end
        meta_we    = 1'b0;
        meta_waddr = used_reg[IDX_W-1:0];
        meta_wdata = {wlen_reg, CNT_W'(1)};
        if (state_reg == ST_APPEND && last_pos) begin
            meta_we = 1'b1;
        end
        if (state_reg == ST_CCMP && char_rdata_reg == buf_rdata_reg && last_pos) begin
            meta_we    = 1'b1;
            meta_waddr = e_reg[IDX_W-1:0];
            meta_wdata = {wlen_reg, (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1)};
        end
    end

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[char_waddr] <= buf_rdata_reg;
        end
        char_rdata_reg <= char_mem[char_raddr];
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[meta_raddr];
        buf_rdata_reg  <= buf_reg[buf_raddr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_QUERY) begin
                        if (s_rank >= RANK_W'(TOP_RANKS) ||
                            USED_W'(s_rank) >= used_reg) begin
                            state_next = ST_OHOLD;
                        end else begin
                            state_next = ST_QRD;
                        end
                    end else if (close_w && !full_reg) begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (e_reg == used_reg) begin
                    state_next = (used_reg >= USED_W'(TABLE_DEPTH)) ? ST_IDLE : ST_APPEND;
                end else begin
                    state_next = ST_META;
                end
            end
            ST_META:   state_next = (rd_len == wlen_reg) ? ST_CRD : ST_LOOKUP;
            ST_CRD:    state_next = ST_CCMP;
            ST_CCMP: begin
                if (char_rdata_reg != buf_rdata_reg) begin
                    state_next = ST_LOOKUP;
                end else if (last_pos) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_CRD;
                end
            end
            ST_APPEND: state_next = last_pos ? ST_IDLE : ST_APPEND;
            ST_QRD: begin
                if (e_reg == used_reg) begin
                    state_next = (pass_reg == rank_reg) ? ST_ORD : ST_QRD;
                end else begin
                    state_next = ST_QCHK;
                end
            end
            ST_QCHK:   state_next = ST_QRD;
            ST_ORD:    state_next = ST_OWAIT;
            ST_OWAIT:  state_next = ST_OHOLD;
            ST_OHOLD: begin
                if (m_ready) begin
                    state_next = m_last ? ST_IDLE : ST_ORD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            wlen_reg    <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    e_reg         <= '0;
                    k_reg         <= '0;
                    pass_reg      <= '0;
                    have_prev_reg <= 1'b0;
                    have_best_reg <= 1'b0;
                    rank_reg      <= s_rank;
                    if (s_valid && s_op == OP_CHAR) begin
                        buf_reg[wlen_reg[POS_W-1:0]] <= s_ch;
                        wlen_reg <= (close_w && full_reg) ? '0 : new_len;
                    end
                    if (s_valid && s_op == OP_QUERY && state_next == ST_OHOLD) begin
                        m_valid_reg <= 1'b1;
                        m_valid_res <= 1'b0;
                        m_out_char  <= '0;
                        m_count     <= '0;
                        m_last      <= 1'b1;
                    end
                end
                ST_LOOKUP: begin
                    k_reg <= '0;
                    if (e_reg == used_reg && used_reg >= USED_W'(TABLE_DEPTH)) begin
                        full_reg <= 1'b1;
                        wlen_reg <= '0;
                    end
                end
                ST_META: begin
                    cnt_reg <= rd_cnt;
                    k_reg   <= '0;
                    if (rd_len != wlen_reg) begin
                        e_reg <= e_reg + USED_W'(1);
                    end
                end
                ST_CCMP: begin
                    if (char_rdata_reg != buf_rdata_reg) begin
                        e_reg <= e_reg + USED_W'(1);
                    end else if (last_pos) begin
                        wlen_reg <= '0;
                    end else begin
                        k_reg <= k_reg + POS_W'(1);
                    end
                end
                ST_APPEND: begin
                    if (last_pos) begin
                        used_reg <= used_reg + USED_W'(1);
                        wlen_reg <= '0;
                    end else begin
                        k_reg <= k_reg + POS_W'(1);
                    end
                end
                ST_QRD: begin
                    if (e_reg == used_reg) begin
                        prev_cnt_reg  <= best_cnt_reg;
                        prev_idx_reg  <= best_idx_reg;
                        have_prev_reg <= 1'b1;
                        have_best_reg <= 1'b0;
                        pass_reg      <= pass_reg + RANK_W'(1);
                        e_reg         <= '0;
                        k_reg         <= '0;
                        if (pass_reg == rank_reg) begin
                            have_best_reg <= 1'b1;
                        end
                    end
                end
                ST_QCHK: begin
                    if (take) begin
                        best_cnt_reg  <= rd_cnt;
                        best_idx_reg  <= e_reg[IDX_W-1:0];
                        best_len_reg  <= rd_len;
                        have_best_reg <= 1'b1;
                    end
                    e_reg <= e_reg + USED_W'(1);
                end
                ST_ORD: begin
                end
                ST_OWAIT: begin
                    m_valid_reg <= 1'b1;
                    m_valid_res <= 1'b1;
                    m_out_char  <= char_rdata_reg;
                    m_count     <= best_cnt_reg;
                    m_last      <= (LEN_W'(k_reg) + LEN_W'(1) == best_len_reg);
                end
                ST_OHOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        k_reg       <= k_reg + POS_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the word frequency table with its own frequency predictor.
`timescale 1ns / 100ps

module tb_top;
    import wft_pkg::*;

    typedef struct packed {
        logic              valid_res;
        logic [7:0]        out_char;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic [10:0]       distinct;
        logic              overflowed;
    } rank_beat_t;

    typedef struct {
        logic              op;
        logic [7:0]        ch;
        logic              word_end;
        logic [RANK_W-1:0] rank;
        bit                typed;
        rank_beat_t        beat;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_op;
    logic [7:0]        s_ch;
    logic              s_word_end;
    logic [RANK_W-1:0] s_rank;
    logic              m_valid;
    logic              m_ready;
    logic              m_valid_res;
    logic [7:0]        m_out_char;
    logic [CNT_W-1:0]  m_count;
    logic              m_last;
    logic [10:0]       m_distinct;
    logic              m_overflowed;

    word_frequency_table dut (.*);

    // Predictor state.
    logic [7:0]       known_chars[TABLE_DEPTH][MAX_WORD_LEN];
    int               known_len[TABLE_DEPTH];
    logic [CNT_W-1:0] known_cnt[TABLE_DEPTH];
    int               known_used;
    logic [7:0]       pend_chars[MAX_WORD_LEN];
    int               pend_len;
    bit               table_full;

    rank_beat_t expected_beats[$];
    int         errors;
    int         beats_seen;
    int         items_sent;
    int         queries_sent;
    bit         quiet;

    initial aclk = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void tally_word();
        int  e;
        bit  same;
        if (!table_full) begin
            for (e = 0; e < known_used; e++) begin
                same = (known_len[e] == pend_len);
                for (int k = 0; same && k < pend_len; k++)
                    if (known_chars[e][k] != pend_chars[k]) same = 0;
                if (same) begin
                    if (known_cnt[e] != '1) known_cnt[e]++;
                    break;
                end
            end
            if (e == known_used) begin
                if (known_used >= TABLE_DEPTH) begin
                    table_full = 1;
                end else begin
                    for (int k = 0; k < pend_len; k++) known_chars[e][k] = pend_chars[k];
                    known_len[e] = pend_len;
                    known_cnt[e] = 1;
                    known_used++;
                end
            end
        end
        pend_len = 0;
    endfunction

    function automatic void predict_item(logic op, logic [7:0] ch, logic we,
                                         logic [RANK_W-1:0] rank);
        rank_beat_t b;
        int         hit;
        int         pos;
        if (op == OP_CHAR) begin
            if (pend_len < MAX_WORD_LEN) pend_chars[pend_len++] = ch;
            if (we || pend_len >= MAX_WORD_LEN) tally_word();
            return;
        end
        b = '0;
        b.distinct = known_used[10:0];
        b.overflowed = table_full;
        hit = -1;
        if (rank < TOP_RANKS && rank < known_used) begin
            for (int i = 0; i < known_used && hit < 0; i++) begin
                pos = 0;
                for (int j = 0; j < known_used; j++)
                    if (known_cnt[j] > known_cnt[i] ||
                        (known_cnt[j] == known_cnt[i] && j < i)) pos++;
                if (pos == rank) hit = i;
            end
        end
        if (hit >= 0 && known_len[hit] > 0) begin
            for (int k = 0; k < known_len[hit]; k++) begin
                b.valid_res = 1;
                b.out_char = known_chars[hit][k];
                b.count = known_cnt[hit];
                b.last = (k + 1 == known_len[hit]);
                expected_beats.push_back(b);
            end
        end else begin
            b.last = 1;
            expected_beats.push_back(b);
        end
    endfunction

    task automatic send_item(logic op, logic [7:0] ch, logic we, logic [RANK_W-1:0] rank);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_ch       <= ch;
        s_word_end <= we;
        s_rank     <= rank;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_QUERY) queries_sent++;
    endtask

    task automatic send_word(logic [7:0] w[$]);
        foreach (w[k]) begin
            send_item(OP_CHAR, w[k], k == w.size() - 1, '0);
            predict_item(OP_CHAR, w[k], k == w.size() - 1, '0);
        end
    endtask

    task automatic send_query(logic [RANK_W-1:0] rank);
        send_item(OP_QUERY, 8'($urandom), 1'($urandom), rank);
        predict_item(OP_QUERY, 8'h00, 1'b0, rank);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge aclk) begin
        rank_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, actual char %h count %0d", $time,
                         m_out_char, m_count);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (m_valid_res !== want.valid_res) begin
                    $display("%0t: valid_res expected %b actual %b", $time,
                             want.valid_res, m_valid_res);
                    errors++;
                end
                if (m_out_char !== want.out_char) begin
                    $display("%0t: out_char expected %h actual %h", $time,
                             want.out_char, m_out_char);
                    errors++;
                end
                if (m_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time,
                             want.count, m_count);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_last);
                    errors++;
                end
                if (m_distinct !== want.distinct) begin
                    $display("%0t: distinct expected %0d actual %0d", $time,
                             want.distinct, m_distinct);
                    errors++;
                end
                if (m_overflowed !== want.overflowed) begin
                    $display("%0t: overflowed expected %b actual %b", $time,
                             want.overflowed, m_overflowed);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t    rows[$];
        stim_row_t    r;
        logic [7:0]   vocab[12][$];
        logic [7:0]   w[$];
        int           len;
        int           n;
        int           wait_cycles;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_CHAR;
        s_ch = '0;
        s_word_end = 1'b0;
        s_rank = '0;
        errors = 0;
        beats_seen = 0;
        items_sent = 0;
        queries_sent = 0;
        quiet = 0;
        known_used = 0;
        pend_len = 0;
        table_full = 0;

        r = '{default: '0};
        // Empty table, word with a zero byte and an all-ones byte, repeats, ranks.
        r.op = OP_QUERY; r.rank = 4'd0; r.typed = 1'b1;
        r.beat = '{1'b0, 8'h00, 32'd0, 1'b1, 11'd0, 1'b0};
        rows.push_back(r);
        r = '{default: '0}; r.ch = 8'h61; r.word_end = 1'b1; rows.push_back(r);
        r.ch = 8'h00; r.word_end = 1'b0; rows.push_back(r);
        r.ch = 8'hFF; r.word_end = 1'b1; rows.push_back(r);
        r.ch = 8'h61; r.word_end = 1'b1; rows.push_back(r);
        r = '{default: '0}; r.op = OP_QUERY; r.rank = 4'd0; rows.push_back(r);
        r.rank = 4'd1; rows.push_back(r);
        r.rank = 4'd15; r.typed = 1'b1;
        r.beat = '{1'b0, 8'h00, 32'd0, 1'b1, 11'd2, 1'b0};
        rows.push_back(r);
        r.rank = 4'd9; rows.push_back(r);
        r = '{default: '0}; r.ch = 8'h62; rows.push_back(r);
        r = '{default: '0}; r.op = OP_QUERY; r.rank = 4'd0; r.ch = 8'hFF; r.word_end = 1'b1;
        rows.push_back(r);
        r = '{default: '0}; r.ch = 8'h63; r.word_end = 1'b1; r.rank = 4'hF; rows.push_back(r);
        r = '{default: '0}; r.op = OP_QUERY; r.rank = 4'd2; rows.push_back(r);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_item(rows[i].op, rows[i].ch, rows[i].word_end, rows[i].rank);
            if (rows[i].typed) expected_beats.push_back(rows[i].beat);
            else predict_item(rows[i].op, rows[i].ch, rows[i].word_end, rows[i].rank);
        end

        // A word of fifty characters closes at the length limit and spills one over.
        for (int k = 0; k < 50; k++) begin
            send_item(OP_CHAR, 8'h41 + k[7:0], 1'b0, '0);
            predict_item(OP_CHAR, 8'h41 + k[7:0], 1'b0, '0);
        end
        send_item(OP_CHAR, 8'h7A, 1'b1, '0);
        predict_item(OP_CHAR, 8'h7A, 1'b1, '0);
        send_query(4'd0);
        send_query(4'd3);

        foreach (vocab[v]) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 49) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) vocab[v].push_back(8'($urandom));
        end
        while (items_sent < 185) begin
            quiet = (items_sent >= 110 && items_sent < 170);
            n = $urandom_range(0, 99);
            if (n < 15) begin
                send_query(4'($urandom));
            end else if (n < 20) begin
                send_item(OP_CHAR, 8'($urandom), 1'($urandom), 4'($urandom));
                predict_item(OP_CHAR, s_ch, s_word_end, '0);
            end else begin
                w = vocab[$urandom_range(0, (n < 60) ? 3 : 11)];
                send_word(w);
            end
        end
        quiet = 0;

        send_word(vocab[0]);
        for (int k = 0; k < 12; k++) send_query(k[RANK_W-1:0]);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_beats.size() != 0 && wait_cycles < 500000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        if (expected_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
            errors++;
        end
        $display("Sent %0d input beats including %0d rank queries; checked %0d result beats.",
                 items_sent, queries_sent, beats_seen);
        $display("Table ended with %0d distinct words, overflow flag %0b.",
                 known_used, table_full);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
